>>> rtl/assert_macros.svh
// assertion helpers for the triangular rank-1 update block
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define TRU_ASSERT_NEVER(lbl, expr, msg) \
  `TRU_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/tru_pkg.sv
// shared types, constants and fixed-point helpers of the triangular rank-1 update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tru_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned NUM_W       = 11;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned EXT_W       = 17;   // holds any index and the largest dimension
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MAX_DIM_DEF = 1024;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD_X = 2'd0,
    ACT_LOAD_Y = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA   = 3'd0,
    REG_ALPHA  = 3'd1,
    REG_ROWS   = 3'd2,
    REG_COLS   = 3'd3,
    REG_UPPER  = 3'd4
  } reg_idx_e;

  // what the back end does with an element
  typedef enum logic [1:0] {
    CLS_UPDATE = 2'd0,
    CLS_PASS   = 2'd1,
    CLS_RANGE  = 2'd2
  } cls_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] beta;
    logic signed [DATA_W-1:0] alpha;
    logic [NUM_W-1:0]         num_rows;
    logic [NUM_W-1:0]         num_cols;
    logic                     upper;
  } cfg_t;

  // one element between front and back; v1 meets alpha first, v2 second
  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] v1;
    logic signed [DATA_W-1:0] v2;
    cls_e                     cls;
  } q_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              empty;
    logic              full;
  } q_stat_t;

  // floor shift of a q16.16 product, then clamp to 32 bits
  function automatic logic signed [DATA_W-1:0] sat_shift(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_W;
    if (sh[63:DATA_W-1] == '0 || sh[63:DATA_W-1] == '1) begin
      return sh[DATA_W-1:0];
    end else if (sh[63]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W-1:0] x,
                                                       input logic signed [DATA_W-1:0] y);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(x) + (DATA_W+1)'(y);
    if (s[DATA_W] == s[DATA_W-1]) begin
      return s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/tru_if.sv
// valid/ready channel interfaces for input items and result items
// depends on tru_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tru_in_if import tru_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, action, row_index, col_index, data_value, input ready);
  modport sink   (input valid, action, row_index, col_index, data_value, output ready);
endinterface

interface tru_out_if import tru_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] new_value;
  logic                     status;

  modport source (output valid, out_row, out_col, new_value, status, input ready);
  modport sink   (input valid, out_row, out_col, new_value, status, output ready);
endinterface

`default_nettype wire

>>> rtl/tru_front.sv
// front end: takes input beats, holds the x and y vector stores, classifies elements
// depends on tru_pkg and tru_if
`timescale 1ns / 1ps
`default_nettype none

module tru_front import tru_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tru_in_if.sink             in_chan,
  input  wire cfg_t          cfg_i,
  input  wire logic [QCNT_W-1:0] q_level_i,
  output logic               push_o,
  output q_item_t            push_item_o
);

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [EXT_W-1:0] DIM = EXT_W'(MAX_DIM);

  logic [DATA_W-1:0] x_mem [MAX_DIM];
  logic [DATA_W-1:0] y_mem [MAX_DIM];

  logic [DATA_W-1:0] x_rd_q, y_rd_q;
  logic              st_v_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic signed [DATA_W-1:0] a_q;
  cls_e              cls_q;

  logic [EXT_W-1:0] row_ext, col_ext;
  logic [AW-1:0]    x_addr, y_addr;
  logic             accept, is_upd, row_ok, col_ok, out_rng, in_tri;
  cls_e             cls_d;

  assign row_ext = EXT_W'(in_chan.row_index);
  assign col_ext = EXT_W'(in_chan.col_index);
  assign x_addr  = row_ext[AW-1:0];
  assign y_addr  = col_ext[AW-1:0];
  assign row_ok  = row_ext < DIM;
  assign col_ok  = col_ext < DIM;

  // room for everything already in flight towards the queue
  assign in_chan.ready = (q_level_i + QCNT_W'(st_v_q)) < QCNT_W'(Q_DEPTH);
  assign accept = in_chan.valid && in_chan.ready;
  assign is_upd = in_chan.action == ACT_UPDATE;

  assign out_rng = ({1'b0, in_chan.row_index} >= cfg_i.num_rows) ||
                   ({1'b0, in_chan.col_index} >= cfg_i.num_cols) || !row_ok || !col_ok;
  assign in_tri  = cfg_i.upper ? (in_chan.col_index >= in_chan.row_index)
                               : (in_chan.row_index >= in_chan.col_index);

  always_comb begin
    if (out_rng) begin
      cls_d = CLS_RANGE;
    end else if (in_tri) begin
      cls_d = CLS_UPDATE;
    end else begin
      cls_d = CLS_PASS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_chan.action == ACT_LOAD_X && row_ok) begin
      x_mem[x_addr] <= in_chan.data_value;
    end
    if (accept && is_upd) begin
      x_rd_q <= x_mem[x_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_chan.action == ACT_LOAD_Y && col_ok) begin
      y_mem[y_addr] <= in_chan.data_value;
    end
    if (accept && is_upd) begin
      y_rd_q <= y_mem[y_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else begin
      st_v_q <= accept && is_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_upd) begin
      row_q <= in_chan.row_index;
      col_q <= in_chan.col_index;
      a_q   <= in_chan.data_value;
      cls_q <= cls_d;
    end
  end

  // upper mode scales x first, lower mode y first
  assign push_o           = st_v_q;
  assign push_item_o.row  = row_q;
  assign push_item_o.col  = col_q;
  assign push_item_o.a    = a_q;
  assign push_item_o.v1   = cfg_i.upper ? x_rd_q : y_rd_q;
  assign push_item_o.v2   = cfg_i.upper ? y_rd_q : x_rd_q;
  assign push_item_o.cls  = cls_q;

endmodule

`default_nettype wire

>>> rtl/tru_queue.sv
// short fifo of classified elements between front and back end
// depends on tru_pkg
`timescale 1ns / 1ps
`default_nettype none

module tru_queue import tru_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t push_item_i,
  input  wire logic    pop_i,
  output q_item_t      head_o,
  output q_stat_t      stat_o
);

  q_item_t           mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    case ({push_i, pop_i})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = level_q == '0;
  assign stat_o.full  = level_q == QCNT_W'(Q_DEPTH);

endmodule

`default_nettype wire

>>> rtl/tru_back.sv
// back end: three-stage q16.16 multiply-add pipeline ending in the result register
// depends on tru_pkg and tru_if
`timescale 1ns / 1ps
`default_nettype none

module tru_back import tru_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire q_item_t head_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  tru_out_if.source    out_chan
);

  logic adv;

  // stage 1: alpha times first vector entry
  logic               s1_v_q;
  logic signed [63:0] s1_p_q;
  q_item_t            s1_q;
  logic signed [63:0] p1;

  // stage 2: second product and beta term
  logic               s2_v_q;
  logic signed [63:0] s2_t_q, s2_b_q;
  q_item_t            s2_q;
  logic signed [DATA_W-1:0] s_val;
  logic signed [63:0] tp, bp;

  // stage 3: result register
  logic               out_v_q;
  logic [IDX_W-1:0]   out_row_q, out_col_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic               out_st_q;
  logic signed [DATA_W-1:0] t_val, b_val, r_val;

  assign adv   = !out_v_q || out_chan.ready;
  assign pop_o = adv && !q_stat_i.empty;

  assign p1    = 64'(cfg_i.alpha) * 64'(head_i.v1);
  assign s_val = sat_shift(s1_p_q);
  assign tp    = 64'(s_val) * 64'(s1_q.v2);
  assign bp    = 64'(cfg_i.beta) * 64'(s1_q.a);
  assign t_val = sat_shift(s2_t_q);
  assign b_val = sat_shift(s2_b_q);
  assign r_val = sat_sum(b_val, t_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_p_q    <= p1;
      s1_q      <= head_i;
      s2_t_q    <= tp;
      s2_b_q    <= bp;
      s2_q      <= s1_q;
      out_row_q <= s2_q.row;
      out_col_q <= s2_q.col;
      out_val_q <= (s2_q.cls == CLS_UPDATE) ? r_val : s2_q.a;
      out_st_q  <= s2_q.cls == CLS_RANGE;
    end
  end

  assign out_chan.valid     = out_v_q;
  assign out_chan.out_row   = out_row_q;
  assign out_chan.out_col   = out_col_q;
  assign out_chan.new_value = out_val_q;
  assign out_chan.status    = out_st_q;

endmodule

`default_nettype wire

>>> rtl/triangular_rank1_update_unit.sv
// top level of the triangular rank-1 update block: config registers, front, queue, back
// depends on tru_pkg, tru_if, tru_front, tru_queue, tru_back and assert_macros.svh
//
//   channel   dir  handshake      beat
//   in_chan   in   valid/ready    action, row_index, col_index, data_value
//   out_chan  out  valid/ready    out_row, out_col, new_value, status
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one beat a cycle on each side while ready is high; loads give no result
// an element's result becomes valid once it has passed the vector store read register,
// the queue entry and three pipeline stages in the back end
// a stalled output freezes the multiply pipeline; the four-entry queue absorbs the
// front, which drops ready once the queue and its feed stage together hold four elements
// reset clears control state only; the vector stores hold nothing until loaded
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangular_rank1_update_unit import tru_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tru_in_if.sink                    in_chan,
  tru_out_if.source                 out_chan,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  cfg_t    cfg_q;
  logic    q_push, q_pop;
  q_item_t q_push_item, q_head;
  q_stat_t q_stat;
  logic    upd_acc, load_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta     <= ONE_Q16;
      cfg_q.alpha    <= ONE_Q16;
      cfg_q.num_rows <= '0;
      cfg_q.num_cols <= '0;
      cfg_q.upper    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BETA:  cfg_q.beta     <= cfg_data_i;
        REG_ALPHA: cfg_q.alpha    <= cfg_data_i;
        REG_ROWS:  cfg_q.num_rows <= cfg_data_i[NUM_W-1:0];
        REG_COLS:  cfg_q.num_cols <= cfg_data_i[NUM_W-1:0];
        REG_UPPER: cfg_q.upper    <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  tru_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .cfg_i       (cfg_q),
    .q_level_i   (q_stat.level),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  tru_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  tru_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .out_chan (out_chan)
  );

  assign upd_acc  = in_chan.valid && in_chan.ready && in_chan.action == ACT_UPDATE;
  assign load_acc = in_chan.valid && in_chan.ready && in_chan.action != ACT_UPDATE;

  `TRU_ASSERT_NEVER(a_queue_overflow, q_push && q_stat.full, "queue written while full")
  `TRU_ASSERT(a_update_queued, upd_acc |=> q_push, "accepted element not queued")
  `TRU_ASSERT(a_load_silent, load_acc |=> !q_push, "load or idle beat queued")

endmodule

`default_nettype wire
